// ===== rtl/shot_pkg.sv =====
// ----------------------------------------------------------------------------
// shot_pkg - shared hold output tracker package
// Types, codes and helpers shared by the tracker top level and its parts.
// ----------------------------------------------------------------------------
`default_nettype none

package shot_pkg;

    // input op codes
    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_LEAVE   = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    // output kind codes
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_KEY   = 2'd1;
    localparam logic [1:0] KIND_MOUSE = 2'd2;

    // field widths
    localparam int OWNER_W = 6;
    localparam int CODE_W  = 16;

    // results per input item, and the width of a counter that holds it
    localparam int RES_LIMIT = 16;
    localparam int CNT_W     = 5;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_APPLY,
        ST_LEAVE,
        ST_CLEAR,
        ST_FLUSH
    } shot_state_t;

    // output identity kept per held entry
    typedef struct packed {
        logic [1:0]        kind;
        logic [CODE_W-1:0] code;
        logic              ext;
    } shot_key_t;

    // one result beat
    typedef struct packed {
        logic [1:0]        kind;
        logic [CODE_W-1:0] code;
        logic              ext;
        logic              key_up;
        logic              full;
    } shot_result_t;

    // sequencer to result buffer
    typedef struct packed {
        logic push;
        logic flush;
    } shot_buf_ctrl_t;

    // result buffer to sequencer
    typedef struct packed {
        logic room;
        logic pend_valid;
    } shot_buf_stat_t;

    // keyboard code 0 and mouse buttons outside 1..4 make no event
    function automatic logic audible(input logic [1:0] kind, input logic [CODE_W-1:0] code);
        logic res;
        res = 1'b0;
        if (kind == KIND_KEY) begin
            res = (code != '0);
        end
        else if (kind == KIND_MOUSE) begin
            res = (code >= CODE_W'(1)) && (code <= CODE_W'(4));
        end
        return res;
    endfunction

    // build a result beat from an output identity
    function automatic shot_result_t make_result(input shot_key_t key, input logic up,
                                                 input logic full);
        shot_result_t r;
        r.kind   = key.kind;
        r.code   = key.code;
        r.ext    = (key.kind == KIND_KEY) ? key.ext : 1'b0;
        r.key_up = up;
        r.full   = full;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/shot_entry_store.sv =====
// ----------------------------------------------------------------------------
// shot_entry_store - held entry identity memory
// One write port and one read port with registered read data, holding the
// kind, code and extended flag of each held entry.
// ----------------------------------------------------------------------------
`default_nettype none

module shot_entry_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire                 clk,
    input  wire                 we,
    input  wire [AW-1:0]        waddr,
    input  shot_pkg::shot_key_t wdata,
    input  wire [AW-1:0]        raddr,
    output shot_pkg::shot_key_t rdata
);

    shot_pkg::shot_key_t mem [DEPTH];
    shot_pkg::shot_key_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/shot_result_buf.sv =====
// ----------------------------------------------------------------------------
// shot_result_buf - result holding stage and output register
// Keeps the newest result back until the next one or the end of the item is
// known, so that the final beat of an item carries tlast.
// ----------------------------------------------------------------------------
`default_nettype none

module shot_result_buf (
    input  wire                      clk,
    input  wire                      rst_n,
    input  shot_pkg::shot_buf_ctrl_t ctrl,
    input  shot_pkg::shot_result_t   push_data,
    output shot_pkg::shot_buf_stat_t stat,
    output logic                     m_axis_tvalid,
    input  wire                      m_axis_tready,
    // emit_kind[1:0], emit_code[17:2], emit_extended[18], key_up[19], zero fill
    output logic [23:0]              m_axis_tdata,
    // table_full[0]
    output logic [0:0]               m_axis_tuser,
    output logic                     m_axis_tlast
);

    shot_pkg::shot_result_t pend_reg, pend_next;
    logic                   pend_valid_reg, pend_valid_next;
    shot_pkg::shot_result_t out_reg, out_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_free;
    logic                   load;

    // move the held beat out when a newer one comes or the item ends
    always_comb
    begin
        out_free        = !out_valid_reg || m_axis_tready;
        load            = pend_valid_reg && out_free && (ctrl.push || ctrl.flush);
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (load) begin
            out_next       = pend_reg;
            out_last_next  = ctrl.flush;
            out_valid_next = 1'b1;
        end
        if (ctrl.push && (!pend_valid_reg || out_free)) begin
            pend_next       = push_data;
            pend_valid_next = 1'b1;
        end
        else if (load) begin
            pend_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign stat.room       = !pend_valid_reg || out_free;
    assign stat.pend_valid = pend_valid_reg;

    // output packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_reg.key_up, out_reg.ext, out_reg.code, out_reg.kind};
    assign m_axis_tuser  = out_reg.full;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/shared_hold_output_tracker.sv =====
// ----------------------------------------------------------------------------
// shared_hold_output_tracker - reference-counted shared hold tracker
// Maps button owners onto shared key and mouse outputs and emits press and
// release beats when the first owner joins or the last owner leaves.
// ----------------------------------------------------------------------------
// One item at a time: an accepted item walks the held entry table one entry
// per cycle through a single compare and mask-update path. A button edge with
// a mapped output runs a match pass over all MAX_ENTRIES entries and then an
// apply step; a falling edge also runs a leave pass, a release-one-owner item
// runs only a leave pass, and release-everything runs one clear pass. A flush
// step closes the item. A stalled result side holds the apply step and the
// leave and clear walks. At most 16 results come from one item; the final
// one carries tlast. Ready is high only between items, while the last result
// of the previous item may still wait at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module shared_hold_output_tracker #(
    parameter int MAX_ENTRIES = 16,
    parameter int MAX_OWNERS  = 64
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // owner[5:0], pressed[6], out_kind[8:7], out_code[24:9], out_extended[25], zero fill
    input  wire  [31:0] s_axis_tdata,
    // op[1:0]
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // emit_kind[1:0], emit_code[17:2], emit_extended[18], key_up[19], zero fill
    output logic [23:0] m_axis_tdata,
    // table_full[0]
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OW = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);

    // input fields
    logic [shot_pkg::OWNER_W-1:0] in_owner;
    logic                         in_pressed;
    shot_pkg::shot_key_t          in_key;
    logic [1:0]                   in_op;
    logic                         in_accept;
    logic                         owner_ok;
    logic [OW-1:0]                owner_idx;

    assign in_owner    = s_axis_tdata[5:0];
    assign in_pressed  = s_axis_tdata[6];
    assign in_key.kind = s_axis_tdata[8:7];
    assign in_key.code = s_axis_tdata[24:9];
    assign in_key.ext  = s_axis_tdata[25];
    assign in_op       = s_axis_tuser;
    assign owner_ok    = ({1'b0, in_owner} < 7'(MAX_OWNERS));
    assign owner_idx   = in_owner[OW-1:0];

    // state
    shot_pkg::shot_state_t state_reg, state_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic                  rise_reg, rise_next;
    shot_pkg::shot_key_t   key_reg, key_next;
    logic [MAX_OWNERS-1:0] bit_reg, bit_next;
    logic                  hit_reg, hit_next;
    logic                  free_reg, free_next;
    logic [IW-1:0]         hit_idx_reg, hit_idx_next;
    logic [IW-1:0]         free_idx_reg, free_idx_next;
    logic [shot_pkg::CNT_W-1:0] count_reg, count_next;
    logic [MAX_OWNERS-1:0] prev_level_reg, prev_level_next;
    logic [MAX_ENTRIES-1:0] entry_valid_reg;
    logic [MAX_OWNERS-1:0] entry_mask_reg [MAX_ENTRIES];

    // table write port
    logic                  tbl_we;
    logic                  tbl_valid;
    logic [MAX_OWNERS-1:0] tbl_mask;

    // identity memory
    logic                  mem_we;
    shot_pkg::shot_key_t   rd_key;

    // result path
    logic                     emit_req;
    logic                     emit_go;
    logic                     step_ok;
    shot_pkg::shot_result_t   emit_data;
    shot_pkg::shot_buf_ctrl_t buf_ctrl;
    shot_pkg::shot_buf_stat_t buf_stat;

    // entry seen at the walk index
    logic                  cur_valid;
    logic [MAX_OWNERS-1:0] cur_mask;
    logic [MAX_OWNERS-1:0] cur_left;
    logic                  cur_match;
    logic                  fin_hit;
    logic                  fin_free;

    assign cur_valid = entry_valid_reg[idx_reg];
    assign cur_mask  = entry_mask_reg[idx_reg];
    assign cur_left  = cur_mask & ~bit_reg;
    assign cur_match = cur_valid && (rd_key == key_reg);
    assign fin_hit   = hit_reg || cur_match;
    assign fin_free  = free_reg || !cur_valid;

    shot_entry_store #(
        .DEPTH (MAX_ENTRIES),
        .AW    (IW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (idx_reg),
        .wdata (key_reg),
        .raddr (idx_next),
        .rdata (rd_key)
    );

    // sequencer: next state, table updates and result requests
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        rise_next       = rise_reg;
        key_next        = key_reg;
        bit_next        = bit_reg;
        hit_next        = hit_reg;
        free_next       = free_reg;
        hit_idx_next    = hit_idx_reg;
        free_idx_next   = free_idx_reg;
        count_next      = count_reg;
        prev_level_next = prev_level_reg;
        tbl_we          = 1'b0;
        tbl_valid       = 1'b0;
        tbl_mask        = '0;
        mem_we          = 1'b0;
        emit_req        = 1'b0;
        emit_data       = shot_pkg::make_result(key_reg, 1'b0, 1'b0);
        buf_ctrl.flush  = 1'b0;
        s_axis_tready   = 1'b0;

        // a result is dropped once the item has given its limit
        emit_go = 1'b0;
        step_ok = 1'b1;

        unique case (state_reg)
            shot_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                idx_next      = '0;
                if (in_accept) begin
                    key_next   = in_key;
                    bit_next   = MAX_OWNERS'(1) << owner_idx;
                    rise_next  = in_pressed;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    count_next = '0;
                    state_next = shot_pkg::ST_FLUSH;
                    priority case (in_op)
                        shot_pkg::OP_SAMPLE:
                        begin
                            if (owner_ok) begin
                                prev_level_next[owner_idx] = in_pressed;
                                if ((in_pressed != prev_level_reg[owner_idx]) &&
                                    ((in_key.kind == shot_pkg::KIND_KEY) ||
                                     (in_key.kind == shot_pkg::KIND_MOUSE))) begin
                                    state_next = shot_pkg::ST_MATCH;
                                end
                                else if (!in_pressed && prev_level_reg[owner_idx]) begin
                                    state_next = shot_pkg::ST_LEAVE;
                                end
                            end
                        end
                        shot_pkg::OP_LEAVE:
                        begin
                            if (owner_ok) begin
                                state_next = shot_pkg::ST_LEAVE;
                            end
                        end
                        shot_pkg::OP_CLEAR:
                        begin
                            prev_level_next = '0;
                            state_next      = shot_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = shot_pkg::ST_FLUSH;
                        end
                    endcase
                end
            end

            // find the matching entry and the lowest free one
            shot_pkg::ST_MATCH:
            begin
                if (cur_match && !hit_reg) begin
                    hit_next     = 1'b1;
                    hit_idx_next = idx_reg;
                end
                if (!cur_valid && !free_reg) begin
                    free_next     = 1'b1;
                    free_idx_next = idx_reg;
                end
                if (idx_reg == LAST_IDX) begin
                    state_next = shot_pkg::ST_APPLY;
                    if (fin_hit) begin
                        idx_next = hit_reg ? hit_idx_reg : idx_reg;
                    end
                    else if (fin_free) begin
                        idx_next = free_reg ? free_idx_reg : idx_reg;
                    end
                end
                else begin
                    idx_next = idx_reg + IW'(1);
                end
            end

            // join, allocate, flag a full table, or leave the matched entry
            shot_pkg::ST_APPLY:
            begin
                if (rise_reg) begin
                    if (hit_reg) begin
                        tbl_we    = 1'b1;
                        tbl_valid = 1'b1;
                        tbl_mask  = cur_mask | bit_reg;
                    end
                    else if (free_reg) begin
                        emit_req  = shot_pkg::audible(key_reg.kind, key_reg.code);
                        emit_data = shot_pkg::make_result(key_reg, 1'b0, 1'b0);
                    end
                    else begin
                        emit_req  = 1'b1;
                        emit_data = shot_pkg::make_result(key_reg, 1'b0, 1'b1);
                    end
                end
                else if (hit_reg && ((cur_mask & bit_reg) != '0)) begin
                    emit_req  = (cur_left == '0) &&
                                shot_pkg::audible(key_reg.kind, key_reg.code);
                    emit_data = shot_pkg::make_result(key_reg, 1'b1, 1'b0);
                end
                emit_go = emit_req && (count_reg < shot_pkg::CNT_W'(shot_pkg::RES_LIMIT));
                step_ok = !emit_go || buf_stat.room;
                if (step_ok) begin
                    if (rise_reg) begin
                        if (!hit_reg && free_reg) begin
                            mem_we    = 1'b1;
                            tbl_we    = 1'b1;
                            tbl_valid = 1'b1;
                            tbl_mask  = bit_reg;
                        end
                        state_next = shot_pkg::ST_FLUSH;
                    end
                    else begin
                        if (hit_reg && ((cur_mask & bit_reg) != '0)) begin
                            tbl_we    = 1'b1;
                            tbl_valid = (cur_left != '0);
                            tbl_mask  = cur_left;
                        end
                        idx_next   = '0;
                        state_next = shot_pkg::ST_LEAVE;
                    end
                end
                else begin
                    tbl_we = 1'b0;
                end
            end

            // take the owner out of every entry, releasing emptied ones
            shot_pkg::ST_LEAVE:
            begin
                if (cur_valid && ((cur_mask & bit_reg) != '0)) begin
                    emit_req  = (cur_left == '0) && shot_pkg::audible(rd_key.kind, rd_key.code);
                    emit_data = shot_pkg::make_result(rd_key, 1'b1, 1'b0);
                end
                emit_go = emit_req && (count_reg < shot_pkg::CNT_W'(shot_pkg::RES_LIMIT));
                step_ok = !emit_go || buf_stat.room;
                if (step_ok) begin
                    if (cur_valid && ((cur_mask & bit_reg) != '0)) begin
                        tbl_we    = 1'b1;
                        tbl_valid = (cur_left != '0);
                        tbl_mask  = cur_left;
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_next = shot_pkg::ST_FLUSH;
                    end
                    else begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
            end

            // release every held entry
            shot_pkg::ST_CLEAR:
            begin
                if (cur_valid) begin
                    emit_req  = shot_pkg::audible(rd_key.kind, rd_key.code);
                    emit_data = shot_pkg::make_result(rd_key, 1'b1, 1'b0);
                end
                emit_go = emit_req && (count_reg < shot_pkg::CNT_W'(shot_pkg::RES_LIMIT));
                step_ok = !emit_go || buf_stat.room;
                if (step_ok) begin
                    if (cur_valid) begin
                        tbl_we    = 1'b1;
                        tbl_valid = 1'b0;
                        tbl_mask  = '0;
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_next = shot_pkg::ST_FLUSH;
                    end
                    else begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
            end

            // hand over the held result with tlast
            shot_pkg::ST_FLUSH:
            begin
                buf_ctrl.flush = buf_stat.pend_valid;
                if (!buf_stat.pend_valid || buf_stat.room) begin
                    state_next = shot_pkg::ST_IDLE;
                    idx_next   = '0;
                end
            end

            default:
            begin
                state_next = shot_pkg::ST_IDLE;
            end
        endcase

        buf_ctrl.push = emit_go && step_ok;
        if (buf_ctrl.push) begin
            count_next = count_reg + shot_pkg::CNT_W'(1);
        end
    end

    assign in_accept = s_axis_tvalid && (state_reg == shot_pkg::ST_IDLE);

    // control state and table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= shot_pkg::ST_IDLE;
            idx_reg         <= '0;
            count_reg       <= '0;
            hit_reg         <= 1'b0;
            free_reg        <= 1'b0;
            prev_level_reg  <= '0;
            entry_valid_reg <= '0;
            for (int e = 0; e < MAX_ENTRIES; e++) begin
                entry_mask_reg[e] <= '0;
            end
        end
        else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            hit_reg        <= hit_next;
            free_reg       <= free_next;
            prev_level_reg <= prev_level_next;
            if (tbl_we) begin
                entry_valid_reg[idx_reg] <= tbl_valid;
                entry_mask_reg[idx_reg]  <= tbl_mask;
            end
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        rise_reg     <= rise_next;
        key_reg      <= key_next;
        bit_reg      <= bit_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
    end

    shot_result_buf u_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (buf_ctrl),
        .push_data     (emit_data),
        .stat          (buf_stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // held entries always have at least one owner
    logic [MAX_ENTRIES-1:0] mask_nz;

    always_comb
    begin
        for (int e = 0; e < MAX_ENTRIES; e++) begin
            mask_nz[e] = (entry_mask_reg[e] != '0);
        end
    end

    // checks
    a_valid_has_owner: assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid_reg == mask_nz)
        else $error("held entry valid bits disagree with owner masks");

    a_idle_nothing_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == shot_pkg::ST_IDLE) |-> !buf_stat.pend_valid)
        else $error("result still held back between items");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= shot_pkg::CNT_W'(shot_pkg::RES_LIMIT))
        else $error("result count beyond limit");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready again right after an accepted beat");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        buf_ctrl.push |-> buf_stat.room)
        else $error("result pushed without room");

endmodule

`default_nettype wire

// ===== tb/sv/tb_shared_hold_output_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shared_hold_output_tracker - self-checking bench for the hold tracker
// Drives button samples, single-owner releases and full clears into the
// tracker and checks every press and release beat against the typed beat of
// a directed row or a local copy of the held entry table. The bench starts
// with a short directed table and then runs random press and release
// sequences with random idling on both streams.
// ----------------------------------------------------------------------------

module tb_shared_hold_output_tracker;
    import shot_pkg::*;

    localparam int SLOTS        = 16;
    localparam int OWNERS       = 64;
    localparam int RAND_ITEMS   = 375;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
    localparam int IDLE_PCT     = 19;
    localparam int POOL_N       = 28;
    localparam int MAX_PRINTS   = 40;
    localparam int HALF_PERIOD  = 5;
    // row marker: expectation comes from the predictor, not the table
    localparam int PREDICTED    = -1;

    // codes the package leaves unnamed
    localparam logic [1:0] OP_NOP   = 2'd3;
    localparam logic [1:0] KIND_BAD = 2'd3;

    // one press or release beat as seen on the result stream
    typedef struct packed {
        logic [1:0]        kind;
        logic [CODE_W-1:0] code;
        logic              ext;
        logic              up;
        logic              full;
        logic              last;
    } hold_beat_t;

    // one row of the directed table
    typedef struct {
        logic [1:0]         op;
        logic [OWNER_W-1:0] owner;
        logic               pressed;
        shot_key_t          key;
        int                 rep;
        int                 n_typed;
        hold_beat_t         typed;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    logic        calm = 1'b0;
    int          cycles = 0;
    int          errors = 0;
    int          beats_seen = 0;

    // predicted held entry table and button levels
    logic               slot_used [SLOTS];
    shot_key_t          slot_key [SLOTS];
    logic [OWNERS-1:0]  slot_owners [SLOTS];
    logic               lvl [OWNERS];
    shot_key_t          held_key [OWNERS];
    shot_key_t          out_pool [POOL_N];

    hold_beat_t         burst [$];
    hold_beat_t         events_due [$];
    stim_row_t          stim_tab [$];

    shared_hold_output_tracker #(
        .MAX_ENTRIES(SLOTS),
        .MAX_OWNERS (OWNERS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    // clock
    always #HALF_PERIOD clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic report_mismatch(input string what, input longint got_v,
                                   input longint want_v);
        if (errors < MAX_PRINTS)
            $display("MISMATCH beat %0d: %s got 0x%0h want 0x%0h",
                     beats_seen, what, got_v, want_v);
        errors++;
    endtask

    // keyboard code 0 and mouse buttons outside 1..4 stay silent
    function automatic logic sounds(input shot_key_t k);
        if (k.kind == KIND_KEY)
            return k.code != '0;
        if (k.kind == KIND_MOUSE)
            return (k.code >= 16'd1) && (k.code <= 16'd4);
        return 1'b0;
    endfunction

    function automatic void add_beat(input shot_key_t k, input logic up, input logic full);
        hold_beat_t b;
        if (burst.size() >= RES_LIMIT)
            return;
        b.kind = k.kind;
        b.code = k.code;
        b.ext  = (k.kind == KIND_KEY) ? k.ext : 1'b0;
        b.up   = up;
        b.full = full;
        b.last = 1'b0;
        burst.push_back(b);
    endfunction

    function automatic void vacate(input int e);
        if (sounds(slot_key[e]))
            add_beat(slot_key[e], 1'b1, 1'b0);
        slot_used[e]   = 1'b0;
        slot_owners[e] = '0;
    endfunction

    // drop one owner from every entry, releasing entries that empty
    function automatic void leave_everywhere(input logic [OWNERS-1:0] who);
        int e;
        for (e = 0; e < SLOTS; e++)
        begin
            if (slot_used[e] && (slot_owners[e] & who) != '0)
            begin
                slot_owners[e] &= ~who;
                if (slot_owners[e] == '0)
                    vacate(e);
            end
        end
    endfunction

    // work out the beats one accepted item causes, into burst
    function automatic void predict_hold(input logic [1:0] op, input logic [OWNER_W-1:0] owner,
                                         input logic pressed, input shot_key_t k);
        logic [OWNERS-1:0] who;
        int e;
        int hit;
        int spare;
        burst.delete();
        who        = '0;
        who[owner] = 1'b1;
        hit        = -1;
        spare      = -1;
        case (op)
            OP_SAMPLE:
            begin
                if (pressed != lvl[owner] && (k.kind == KIND_KEY || k.kind == KIND_MOUSE))
                begin
                    for (e = 0; e < SLOTS; e++)
                        if (hit < 0 && slot_used[e] && slot_key[e] == k)
                            hit = e;
                    if (pressed)
                    begin
                        if (hit >= 0)
                            slot_owners[hit] |= who;
                        else
                        begin
                            for (e = 0; e < SLOTS; e++)
                                if (spare < 0 && !slot_used[e])
                                    spare = e;
                            // no free entry: the press is dropped and flagged
                            if (spare < 0)
                                add_beat(k, 1'b0, 1'b1);
                            else
                            begin
                                slot_used[spare]   = 1'b1;
                                slot_key[spare]    = k;
                                slot_owners[spare] = who;
                                if (sounds(k))
                                    add_beat(k, 1'b0, 1'b0);
                            end
                        end
                    end
                    else if (hit >= 0)
                    begin
                        slot_owners[hit] &= ~who;
                        if (slot_owners[hit] == '0)
                            vacate(hit);
                    end
                end
                // a falling edge also lets go of everything the owner holds
                if (!pressed && lvl[owner])
                    leave_everywhere(who);
                lvl[owner] = pressed;
            end
            OP_LEAVE:
                leave_everywhere(who);
            OP_CLEAR:
            begin
                for (e = 0; e < SLOTS; e++)
                    if (slot_used[e])
                        vacate(e);
                for (e = 0; e < OWNERS; e++)
                    lvl[e] = 1'b0;
            end
            default:
                ;
        endcase
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
    endfunction

    function automatic shot_key_t random_key();
        shot_key_t k;
        k.kind = $urandom_range(0, 3);
        k.code = $urandom_range(0, 65535);
        k.ext  = $urandom_range(0, 1);
        return k;
    endfunction

    function automatic stim_row_t row(input logic [1:0] op, input int owner,
                                      input logic pressed, input logic [1:0] kind,
                                      input logic [CODE_W-1:0] code, input logic ext,
                                      input int rep, input int n_typed, input logic t_ext,
                                      input logic t_up, input logic t_full);
        stim_row_t s;
        s.op      = op;
        s.owner   = owner[OWNER_W-1:0];
        s.pressed = pressed;
        s.key     = '{kind, code, ext};
        s.rep     = rep;
        s.n_typed = n_typed;
        s.typed   = '{kind, code, t_ext, t_up, t_full, 1'b1};
        return s;
    endfunction

    // present one item, wait for it to be taken, then log what it should cause
    task automatic send_item(input logic [1:0] op, input logic [OWNER_W-1:0] owner,
                             input logic pressed, input shot_key_t k, input int n_typed,
                             input hold_beat_t typed);
        int j;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, k.ext, k.code, k.kind, pressed, owner};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_hold(op, owner, pressed, k);
        if (n_typed == PREDICTED)
        begin
            for (j = 0; j < burst.size(); j++)
                events_due.push_back(burst[j]);
        end
        else if (n_typed > 0)
            events_due.push_back(typed);
    endtask

    // result checker
    always @(posedge clk)
    begin
        hold_beat_t got;
        hold_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind = m_axis_tdata[1:0];
            got.code = m_axis_tdata[17:2];
            got.ext  = m_axis_tdata[18];
            got.up   = m_axis_tdata[19];
            got.full = m_axis_tuser[0];
            got.last = m_axis_tlast;
            if (events_due.size() == 0)
                report_mismatch("beat with nothing pending, code", got.code, 0);
            else
            begin
                want = events_due.pop_front();
                if (got.kind != want.kind)
                    report_mismatch("emit_kind", got.kind, want.kind);
                if (got.code != want.code)
                    report_mismatch("emit_code", got.code, want.code);
                if (got.ext != want.ext)
                    report_mismatch("emit_extended", got.ext, want.ext);
                if (got.up != want.up)
                    report_mismatch("key_up", got.up, want.up);
                if (got.full != want.full)
                    report_mismatch("table_full", got.full, want.full);
                if (got.last != want.last)
                    report_mismatch("last", got.last, want.last);
            end
            beats_seen++;
        end
    end

    // stimulus
    initial
    begin
        int n;
        int r;
        int i;
        int pick;
        logic [1:0] op;
        logic [OWNER_W-1:0] owner;
        logic pressed;
        shot_key_t k;

        // empty table, all buttons up
        for (i = 0; i < SLOTS; i++)
        begin
            slot_used[i]   = 1'b0;
            slot_key[i]    = '0;
            slot_owners[i] = '0;
        end
        for (i = 0; i < OWNERS; i++)
        begin
            lvl[i]      = 1'b0;
            held_key[i] = '0;
        end

        // outputs that owners share: silent codes and extremes first
        for (i = 0; i < POOL_N; i++)
            out_pool[i] = '{KIND_KEY, 16'($urandom_range(1, 65535)), 1'($urandom_range(0, 1))};
        out_pool[0]  = '{KIND_KEY, 16'h0000, 1'b0};
        out_pool[1]  = '{KIND_KEY, 16'hFFFF, 1'b1};
        out_pool[2]  = '{KIND_KEY, 16'h001E, 1'b0};
        out_pool[3]  = '{KIND_KEY, 16'h001E, 1'b1};
        out_pool[4]  = '{KIND_MOUSE, 16'h0001, 1'b0};
        out_pool[5]  = '{KIND_MOUSE, 16'h0002, 1'b1};
        out_pool[6]  = '{KIND_MOUSE, 16'h0003, 1'b0};
        out_pool[7]  = '{KIND_MOUSE, 16'h0004, 1'b0};
        out_pool[8]  = '{KIND_MOUSE, 16'h0000, 1'b0};
        out_pool[9]  = '{KIND_MOUSE, 16'h0005, 1'b0};
        out_pool[10] = '{KIND_MOUSE, 16'hFFFF, 1'b1};

        // directed table: op, owner, level, kind, code, ext, repeat,
        // typed beats, typed ext, typed key_up, typed table_full
        // first owner presses, second joins quietly, last to leave releases
        stim_tab.push_back(row(OP_SAMPLE, 0, 1, KIND_KEY, 16'h001E, 0, 1, 1, 0, 0, 0));
        stim_tab.push_back(row(OP_SAMPLE, 1, 1, KIND_KEY, 16'h001E, 0, 1, 0, 0, 0, 0));
        stim_tab.push_back(row(OP_SAMPLE, 0, 0, KIND_KEY, 16'h001E, 0, 1, 0, 0, 0, 0));
        stim_tab.push_back(row(OP_SAMPLE, 1, 0, KIND_KEY, 16'h001E, 0, 1, 1, 0, 1, 0));
        // top owner, all-ones extended code, mouse drops the extended flag
        stim_tab.push_back(row(OP_SAMPLE, 63, 1, KIND_KEY, 16'hFFFF, 1, 1, 1, 1, 0, 0));
        stim_tab.push_back(row(OP_SAMPLE, 2, 1, KIND_MOUSE, 16'h0004, 1, 1, 1, 0, 0, 0));
        // silent outputs are held but say nothing
        stim_tab.push_back(row(OP_SAMPLE, 3, 1, KIND_MOUSE, 16'h0005, 0, 1, 0, 0, 0, 0));
        stim_tab.push_back(row(OP_SAMPLE, 4, 1, KIND_KEY, 16'h0000, 0, 1, 0, 0, 0, 0));
        // no output mapped
        stim_tab.push_back(row(OP_SAMPLE, 5, 1, KIND_NONE, 16'h1234, 0, 1, 0, 0, 0, 0));
        stim_tab.push_back(row(OP_SAMPLE, 6, 1, KIND_BAD, 16'hABCD, 1, 1, 0, 0, 0, 0));
        // single-owner release
        stim_tab.push_back(row(OP_LEAVE, 63, 0, KIND_KEY, 16'hFFFF, 1, 1, 1, 1, 1, 0));
        stim_tab.push_back(row(OP_SAMPLE, 7, 1, KIND_MOUSE, 16'h0001, 0, 1, 1, 0, 0, 0));
        // unknown op, then a level with no edge
        stim_tab.push_back(row(OP_NOP, 7, 0, KIND_MOUSE, 16'h0001, 0, 1, 0, 0, 0, 0));
        stim_tab.push_back(row(OP_SAMPLE, 7, 1, KIND_MOUSE, 16'h0001, 0, 1, 0, 0, 0, 0));
        // falling edge on another output still lets go of the held mouse button
        stim_tab.push_back(row(OP_SAMPLE, 2, 0, KIND_KEY, 16'h0030, 0, 1, PREDICTED, 0, 0, 0));
        stim_tab.push_back(row(OP_CLEAR, 0, 0, KIND_NONE, 16'h0000, 0, 1, PREDICTED, 0, 0, 0));
        // fill the table, then two presses that find no room
        stim_tab.push_back(row(OP_SAMPLE, 8, 1, KIND_KEY, 16'h0100, 0, 16, PREDICTED, 0, 0, 0));
        stim_tab.push_back(row(OP_SAMPLE, 40, 1, KIND_KEY, 16'h0200, 1, 1, 1, 1, 0, 1));
        stim_tab.push_back(row(OP_SAMPLE, 41, 1, KIND_MOUSE, 16'h0003, 1, 1, 1, 0, 0, 1));
        stim_tab.push_back(row(OP_CLEAR, 0, 0, KIND_NONE, 16'h0000, 0, 1, PREDICTED, 0, 0, 0));

        // reset
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (stim_tab[r])
        begin
            for (i = 0; i < stim_tab[r].rep; i++)
            begin
                k      = stim_tab[r].key;
                k.code = k.code + CODE_W'(i);
                owner  = stim_tab[r].owner + OWNER_W'(i);
                send_item(stim_tab[r].op, owner, stim_tab[r].pressed, k,
                          stim_tab[r].n_typed, stim_tab[r].typed);
            end
        end

        // random part: mostly clean press and release sequences per owner
        for (n = 0; n < RAND_ITEMS; n++)
        begin
            calm    = (n >= 150) && (n < 230);
            pick    = $urandom_range(0, 99);
            op      = OP_SAMPLE;
            owner   = $urandom_range(0, OWNERS - 1);
            pressed = $urandom_range(0, 1);
            k       = random_key();
            if (pick < 2)
                op = OP_CLEAR;
            else if (pick < 7)
                op = OP_LEAVE;
            else if (pick < 9)
                op = OP_NOP;
            else
            begin
                if ($urandom_range(0, 99) < 85)
                    owner = $urandom_range(0, 31);
                if (!lvl[owner])
                begin
                    pressed = ($urandom_range(0, 99) < 90);
                    if ($urandom_range(0, 99) < 88)
                        k = out_pool[$urandom_range(0, POOL_N - 1)];
                    held_key[owner] = k;
                end
                else
                begin
                    pressed = ($urandom_range(0, 99) < 50);
                    k = ($urandom_range(0, 99) < 80) ? held_key[owner]
                                                      : out_pool[$urandom_range(0, POOL_N - 1)];
                end
            end
            send_item(op, owner, pressed, k, PREDICTED, '0);
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        // drain
        while (events_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
